/* sv/lnt_pkg.sv */
// ----------------------------------------------------------------------------
// lnt_pkg: shared types and constants for the link neighbor table
// Item and result words, controller commands and status, state encoding.
// ----------------------------------------------------------------------------
package lnt_pkg;

  localparam int NEIGHBORS_DEF = 16;
  localparam int PORTS_DEF     = 32;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_REG   = 2'd2;
  localparam logic [1:0] FUNC_FRAME = 2'd3;

  localparam logic [1:0] KIND_DISC  = 2'd0;
  localparam logic [1:0] KIND_EXP   = 2'd1;
  localparam logic [1:0] KIND_PROBE = 2'd2;

  localparam logic [1:0] CFG_IDLE   = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;
  localparam logic [1:0] CFG_MISS   = 2'd2;
  localparam logic [1:0] CFG_ETYPE  = 2'd3;

  localparam logic [7:0] OUI_B0 = 8'h08;
  localparam logic [7:0] OUI_B1 = 8'h00;
  localparam logic [7:0] OUI_B2 = 8'h56;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] port_in;
    logic [63:0] peer_dpid;
    logic [15:0] peer_port;
    logic [15:0] hold_seconds;
    logic [15:0] frame_ethertype;
    logic [47:0] source_mac;
    logic        remote_up;
    logic        local_up;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port_out;
    logic [63:0] dpid_out;
    logic [15:0] peer_port_out;
    logic [15:0] advertised_hold;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXP, ST_PRB, ST_MATCH, ST_FIN, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic step_exp;
    logic step_prb;
    logic step_match;
    logic idx_one;
    logic fin;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       in_rup;
    logic       in_ok;
    logic       prb_ok;
    logic       end_e;
    logic       end_p;
    logic       blocked;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

endpackage

/* sv/link_neighbor_table_with_probes_top.sv */
// ----------------------------------------------------------------------------
// link_neighbor_table_with_probes_top: link neighbor table with probe timers
// Neighbor discovery table with aging and per-port probe scheduling.
// ----------------------------------------------------------------------------
// One input word is taken at a time. Register-port and reset-ports words, a
// tick with the remote side down and a probe frame that fails the filter are
// done as they are taken, with no scan. A probe-frame word that passes scans
// every neighbor entry once, one entry a cycle, then commits. A tick scans the
// entries for expiry and then, when probes run, ports 1..highest registered
// port, one per cycle while the result side does not stall. Results flow
// through a pending stage and an output register, so a finished result may
// wait on the output while the next input word is taken; the final result
// of a word carries last.
module link_neighbor_table_with_probes_top #(
  parameter int NEIGHBORS = lnt_pkg::NEIGHBORS_DEF,
  parameter int PORTS     = lnt_pkg::PORTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lnt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lnt_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  lnt_pkg::cmd_t  cmd;
  lnt_pkg::stat_t st;

  // sequence the scans
  lnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // hold the table and drive results
  lnt_dp #(
    .NEIGHBORS (NEIGHBORS),
    .PORTS     (PORTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* sv/lnt_ctrl.sv */
// ----------------------------------------------------------------------------
// lnt_ctrl: sequencing state machine
// Steps the datapath through expiry, probe and match scans.
// ----------------------------------------------------------------------------
module lnt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lnt_pkg::stat_t st,
  output lnt_pkg::cmd_t  cmd
);

  lnt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lnt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lnt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (st.func == lnt_pkg::FUNC_TICK && st.in_rup) state_nxt = lnt_pkg::ST_EXP;
          else if (st.func == lnt_pkg::FUNC_FRAME && st.in_ok) state_nxt = lnt_pkg::ST_MATCH;
        end
      end
      lnt_pkg::ST_EXP: begin
        if (!st.blocked && st.end_e)
          state_nxt = st.prb_ok ? lnt_pkg::ST_PRB : lnt_pkg::ST_FLUSH;
      end
      lnt_pkg::ST_PRB: begin
        if (!st.blocked && st.end_p) state_nxt = lnt_pkg::ST_FLUSH;
      end
      lnt_pkg::ST_MATCH: begin
        if (st.end_e) state_nxt = lnt_pkg::ST_FIN;
      end
      lnt_pkg::ST_FIN:   state_nxt = lnt_pkg::ST_FLUSH;
      lnt_pkg::ST_FLUSH: begin
        if (!st.pend_valid || st.out_free) state_nxt = lnt_pkg::ST_IDLE;
      end
      default: state_nxt = lnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      lnt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lnt_pkg::ST_EXP: begin
        cmd.step_exp = !st.blocked;
        cmd.idx_one  = !st.blocked && st.end_e;
      end
      lnt_pkg::ST_PRB:   cmd.step_prb   = !st.blocked;
      lnt_pkg::ST_MATCH: cmd.step_match = 1'b1;
      lnt_pkg::ST_FIN:   cmd.fin        = 1'b1;
      lnt_pkg::ST_FLUSH: cmd.flush      = st.pend_valid && st.out_free;
      default: ;
    endcase
  end

endmodule

/* sv/lnt_dp.sv */
// ----------------------------------------------------------------------------
// lnt_dp: neighbor table, port timers and result registers
// Holds all table state and does one entry or one port per step.
// ----------------------------------------------------------------------------
module lnt_dp #(
  parameter int NEIGHBORS = lnt_pkg::NEIGHBORS_DEF,
  parameter int PORTS     = lnt_pkg::PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lnt_pkg::in_word_t in_data,
  output lnt_pkg::out_word_t out_data,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  lnt_pkg::cmd_t     cmd,
  output lnt_pkg::stat_t    st
);

  localparam int EW = $clog2(NEIGHBORS);
  localparam int PW = $clog2(PORTS);
  localparam int IW = (EW > PW) ? EW : PW;
  localparam int CW = $clog2(NEIGHBORS + 1);
  localparam logic [IW-1:0] LAST_E = IW'(NEIGHBORS - 1);

  logic [11:0] idle_int_r, act_int_r;
  logic [3:0]  miss_r;
  logic [15:0] etype_r;

  logic          ent_v_r   [NEIGHBORS];
  logic [PW-1:0] ent_lp_r  [NEIGHBORS];
  logic [63:0]   ent_dp_r  [NEIGHBORS];
  logic [15:0]   ent_pp_r  [NEIGHBORS];
  logic [31:0]   ent_ex_r  [NEIGHBORS];
  logic [CW-1:0] cnt_r     [PORTS];
  logic          preg_r    [PORTS];
  logic [31:0]   due_r     [PORTS];
  logic [PW-1:0] hi_r;
  logic          pen_r;
  logic [31:0]   now_r;
  logic [63:0]   own_r;

  lnt_pkg::in_word_t  it_r;
  logic [IW-1:0]      idx_r;
  logic               mfound_r, ffound_r;
  logic [EW-1:0]      midx_r, fidx_r;
  lnt_pkg::out_word_t pend_r, out_r;
  logic               pend_v_r, out_v_r;

  logic [EW-1:0]      ei;
  logic [PW-1:0]      pi, ilp;
  logic               hit_p, ematch, out_take, out_free;
  logic [11:0]        per;
  logic               new_v;
  lnt_pkg::out_word_t new_w;
  lnt_pkg::out_word_t flush_w;

  assign ei  = idx_r[EW-1:0];
  assign pi  = idx_r[PW-1:0];
  assign ilp = it_r.port_in[PW-1:0];
  logic reach_e, reach_p;
  assign reach_e = !(now_r[31:0] - ent_ex_r[ei] >= 32'h8000_0000);
  assign reach_p = !(now_r[31:0] - due_r[pi] >= 32'h8000_0000);
  assign ematch  = ent_v_r[ei] && ent_lp_r[ei] == ilp && ent_dp_r[ei] == it_r.peer_dpid
                   && ent_pp_r[ei] == it_r.peer_port;
  assign hit_p   = preg_r[pi] && reach_p;
  assign per     = (cnt_r[pi] == '0) ? idle_int_r : act_int_r;
  assign out_take = out_v_r && !out_stall;
  assign out_free = !out_v_r || out_take;

  always_comb begin
    flush_w      = pend_r;
    flush_w.last = 1'b1;
  end

  always_comb begin
    new_v = 1'b0;
    new_w = '0;
    if (cmd.step_exp && ent_v_r[ei] && reach_e) begin
      new_v = 1'b1;
      new_w.kind          = lnt_pkg::KIND_EXP;
      new_w.port_out      = 16'(ent_lp_r[ei]);
      new_w.dpid_out      = ent_dp_r[ei];
      new_w.peer_port_out = ent_pp_r[ei];
    end else if (cmd.step_prb && hit_p) begin
      new_v = 1'b1;
      new_w.kind            = lnt_pkg::KIND_PROBE;
      new_w.port_out        = 16'(pi);
      new_w.dpid_out        = own_r;
      new_w.advertised_hold = 16'(miss_r) * 16'(per);
    end else if (cmd.fin && !mfound_r && ffound_r && it_r.remote_up) begin
      new_v = 1'b1;
      new_w.kind          = lnt_pkg::KIND_DISC;
      new_w.port_out      = it_r.port_in;
      new_w.dpid_out      = it_r.peer_dpid;
      new_w.peer_port_out = it_r.peer_port;
    end
  end

  always_comb begin
    st = '0;
    st.func       = in_data.func;
    st.in_rup     = in_data.remote_up;
    st.in_ok      = in_data.frame_ethertype == etype_r
                    && in_data.source_mac[47:40] == lnt_pkg::OUI_B0
                    && in_data.source_mac[39:32] == lnt_pkg::OUI_B1
                    && in_data.source_mac[31:24] == lnt_pkg::OUI_B2
                    && 32'(in_data.port_in) < PORTS;
    st.prb_ok     = pen_r && it_r.local_up && hi_r != '0;
    st.end_e      = idx_r == LAST_E;
    st.end_p      = pi == hi_r;
    st.blocked    = pend_v_r && !out_free &&
                    ((ent_v_r[ei] && reach_e && idx_r <= LAST_E) || hit_p);
    st.pend_valid = pend_v_r;
    st.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_int_r <= 12'd15;
      act_int_r  <= 12'd5;
      miss_r     <= 4'd3;
      etype_r    <= 16'd35020;
      hi_r       <= '0;
      pen_r      <= 1'b0;
      now_r      <= '0;
      own_r      <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      for (int i = 0; i < NEIGHBORS; i++) ent_v_r[i] <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        cnt_r[p]  <= '0;
        preg_r[p] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lnt_pkg::CFG_IDLE:   idle_int_r <= cfg_wdata[11:0];
          lnt_pkg::CFG_ACTIVE: act_int_r  <= cfg_wdata[11:0];
          lnt_pkg::CFG_MISS:   miss_r     <= cfg_wdata[3:0];
          lnt_pkg::CFG_ETYPE:  etype_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        unique case (in_data.func)
          lnt_pkg::FUNC_TICK: now_r <= now_r + 32'd1;
          lnt_pkg::FUNC_RESET: begin
            own_r <= in_data.peer_dpid;
            pen_r <= 1'b1;
            hi_r  <= '0;
            for (int p = 0; p < PORTS; p++) begin
              cnt_r[p]  <= '0;
              preg_r[p] <= 1'b0;
            end
          end
          lnt_pkg::FUNC_REG: begin
            if (32'(in_data.port_in) < PORTS) begin
              preg_r[in_data.port_in[PW-1:0]] <= 1'b1;
              if (in_data.port_in[PW-1:0] > hi_r) hi_r <= in_data.port_in[PW-1:0];
            end
          end
          default: ;
        endcase
      end
      if (cmd.step_exp && ent_v_r[ei] && reach_e) begin
        ent_v_r[ei] <= 1'b0;
        if (cnt_r[ent_lp_r[ei]] != '0) cnt_r[ent_lp_r[ei]] <= cnt_r[ent_lp_r[ei]] - CW'(1);
      end
      if (cmd.fin && !mfound_r && ffound_r) begin
        ent_v_r[fidx_r] <= 1'b1;
        cnt_r[ilp]      <= cnt_r[ilp] + CW'(1);
      end
      // advance the result pair: pend -> out, new -> pend
      if (new_v) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) out_v_r <= 1'b1;
        else if (out_take) out_v_r <= 1'b0;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r     <= in_data;
      idx_r    <= '0;
      mfound_r <= 1'b0;
      ffound_r <= 1'b0;
      if (in_data.func == lnt_pkg::FUNC_REG && 32'(in_data.port_in) < PORTS)
        due_r[in_data.port_in[PW-1:0]] <= now_r + 32'(idle_int_r);
    end
    if (cmd.idx_one) idx_r <= IW'(1);
    else if (cmd.step_exp || cmd.step_prb || cmd.step_match) idx_r <= idx_r + IW'(1);
    if (cmd.step_prb && hit_p) due_r[pi] <= now_r + 32'(per);
    if (cmd.step_match) begin
      if (ematch && !mfound_r) begin
        mfound_r <= 1'b1;
        midx_r   <= ei;
      end
      if (!ent_v_r[ei] && !ffound_r) begin
        ffound_r <= 1'b1;
        fidx_r   <= ei;
      end
    end
    if (cmd.fin) begin
      if (mfound_r) begin
        ent_ex_r[midx_r] <= now_r + 32'(it_r.hold_seconds);
      end else if (ffound_r) begin
        ent_lp_r[fidx_r] <= ilp;
        ent_dp_r[fidx_r] <= it_r.peer_dpid;
        ent_pp_r[fidx_r] <= it_r.peer_port;
        ent_ex_r[fidx_r] <= now_r + 32'(it_r.hold_seconds);
      end
    end
    // a pending word always carries last low until it is flushed
    if (new_v) begin
      pend_r <= new_w;
      if (pend_v_r) out_r <= pend_r;
    end else if (cmd.flush) begin
      out_r <= flush_w;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_v_r;

endmodule
